>>> hdl/hrsm_pkg.sv
package hrsm_pkg;

   localparam int RING_DEPTH = 12;
   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = $clog2(RING_DEPTH * 255 + 1);

   localparam int DIV_W = 16;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam logic [DIV_W-1:0] RATE_NUM = 16'd60000;

   localparam int IR_W = 18;
   localparam int MS_W = 20;
   localparam int TIME_W = 32;
   localparam int RATE_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [1:0] {
      MODE_WAIT  = 2'd0,
      MODE_STAB  = 2'd1,
      MODE_MON   = 2'd2,
      MODE_SLEEP = 2'd3
   } mode_type;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FINGER_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STABILIZE_MS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MONITOR_MS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEEP_MS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_LOW = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_HIGH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_PRESET = 3'd6;

   localparam logic [IR_W-1:0] FINGER_THRESHOLD_RST = 18'd50000;
   localparam logic [MS_W-1:0] STABILIZE_MS_RST = 20'd15000;
   localparam logic [MS_W-1:0] MONITOR_MS_RST = 20'd10000;
   localparam logic [MS_W-1:0] SLEEP_MS_RST = 20'd50000;
   localparam logic [RATE_W-1:0] RATE_LOW_RST = 8'd40;
   localparam logic [RATE_W-1:0] RATE_HIGH_RST = 8'd180;
   localparam logic [RATE_W-1:0] RING_PRESET_RST = 8'd70;

endpackage

>>> hdl/hrsm_if.sv
interface hrsm_req_if;
   import hrsm_pkg::*;
   logic            valid;
   logic            ready;
   logic            req_type;
   logic [IR_W-1:0] ir_level;
   logic            beat_seen;

   modport source (output valid, req_type, ir_level, beat_seen, input ready);
   modport sink (input valid, req_type, ir_level, beat_seen, output ready);
endinterface

interface hrsm_rsp_if;
   import hrsm_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic              finger_present;
   logic              beat_accepted;
   logic [RATE_W-1:0] instant_rate;
   logic              avg_valid;
   logic [RATE_W-1:0] avg_rate;

   modport source (output valid, mode, finger_present, beat_accepted, instant_rate,
                   avg_valid, avg_rate, input ready);
   modport sink (input valid, mode, finger_present, beat_accepted, instant_rate,
                 avg_valid, avg_rate, output ready);
endinterface

interface hrsm_csr_if;
   import hrsm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/heart_rate_session_monitor_core.sv
// Heart-rate session monitor. Each request is a millisecond tick or a sensor sample and
// gives exactly one response. A tick, a sample without a beat and a sample taken while
// sleeping go from the execute state straight to the response register; a sample whose
// beat is rejected passes the rate check first; a sample whose beat is accepted also runs
// the shared 16-step restoring divider, once for 60000/interval and, unless every ring
// entry is zero, once for the ring sum over the count of nonzero entries, with the
// read-modify-write of the rate ring memory in between. A new request is taken the cycle
// after the previous one has been handed to the response register, and a response left
// waiting holds the block. The ring entries carry valid bits, so no clearing pass follows
// reset or the end of sleep. Configuration writes are taken in any cycle; ring_preset is
// applied at the next end of sleep, while reset restores the default preset.
module heart_rate_session_monitor_core (
   input logic        clock,
   input logic        reset,
   hrsm_req_if.sink   req,
   hrsm_rsp_if.source rsp,
   hrsm_csr_if.sink   csr
);
   import hrsm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_CHECK,
      S_DIV_RATE,
      S_READ,
      S_UPDATE,
      S_DIV_AVG,
      S_DONE
   } state_type;

   state_type state_ff;

   logic [IR_W-1:0]   thr_ff;
   logic [MS_W-1:0]   stab_ff;
   logic [MS_W-1:0]   mon_ff;
   logic [MS_W-1:0]   sleep_ff;
   logic [RATE_W-1:0] low_ff;
   logic [RATE_W-1:0] high_ff;
   logic [RATE_W-1:0] preset_cfg_ff;

   logic              req_type_ff;
   logic [IR_W-1:0]   ir_ff;
   logic              beat_ff;

   mode_type          mode_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] last_ff;
   logic [MS_W-1:0]   phase_ff;
   logic              finger_ff;
   logic [TIME_W-1:0] delta_ff;
   logic              mon_beat_ff;
   logic              acc_ff;
   logic [RATE_W-1:0] inst_ff;
   logic              avalid_ff;
   logic [RATE_W-1:0] avg_ff;

   logic [RATE_W-1:0]     preset_ff;
   logic [RATE_W-1:0]     ring_mem [RING_DEPTH];
   logic [RATE_W-1:0]     ring_rd_ff;
   logic [RING_DEPTH-1:0] ring_valid_ff;
   logic [PTR_W-1:0]      ptr_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic [DIV_W:0]         div_rem_ff;
   logic [DIV_W-1:0]       div_quo_ff;
   logic [DIV_W:0]         div_den_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_mode_ff;
   logic                   rsp_finger_ff;
   logic                   rsp_acc_ff;
   logic [RATE_W-1:0]      rsp_inst_ff;
   logic                   rsp_avalid_ff;
   logic [RATE_W-1:0]      rsp_avg_ff;

   logic [MS_W-1:0]        phase_in;
   logic                   finger_in;
   logic [TIME_W+RATE_W-1:0] lo_prod;
   logic [TIME_W+RATE_W-1:0] hi_prod;
   logic                   rate_ok;
   logic [DIV_W:0]         rem_sh;
   logic                   div_ge;
   logic [DIV_W:0]         rem_in;
   logic [DIV_W-1:0]       quo_in;
   logic [RATE_W-1:0]      old_entry;
   logic [SUM_W-1:0]       sum_in;
   logic [CNT_W-1:0]       cnt_in;
   logic [PTR_W-1:0]       ptr_in;
   logic                   out_free;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.mode = rsp_mode_ff;
   assign rsp.finger_present = rsp_finger_ff;
   assign rsp.beat_accepted = rsp_acc_ff;
   assign rsp.instant_rate = rsp_inst_ff;
   assign rsp.avg_valid = rsp_avalid_ff;
   assign rsp.avg_rate = rsp_avg_ff;

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      phase_in = phase_ff + MS_W'(1);
      finger_in = (ir_ff > thr_ff);
      lo_prod = (TIME_W+RATE_W)'(low_ff) * (TIME_W+RATE_W)'(delta_ff);
      hi_prod = (TIME_W+RATE_W)'(high_ff) * (TIME_W+RATE_W)'(delta_ff);
      rate_ok = (lo_prod < (TIME_W+RATE_W)'(RATE_NUM))
             && (hi_prod > (TIME_W+RATE_W)'(RATE_NUM));
      rem_sh = {div_rem_ff[DIV_W-1:0], div_quo_ff[DIV_W-1]};
      div_ge = (rem_sh >= div_den_ff);
      rem_in = div_ge ? (rem_sh - div_den_ff) : rem_sh;
      quo_in = {div_quo_ff[DIV_W-2:0], div_ge};
      old_entry = ring_valid_ff[ptr_ff] ? ring_rd_ff : preset_ff;
      sum_in = sum_ff - SUM_W'(old_entry) + SUM_W'(inst_ff);
      cnt_in = cnt_ff - CNT_W'(old_entry != '0) + CNT_W'(inst_ff != '0);
      ptr_in = (ptr_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : (ptr_ff + PTR_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= FINGER_THRESHOLD_RST;
         stab_ff <= STABILIZE_MS_RST;
         mon_ff <= MONITOR_MS_RST;
         sleep_ff <= SLEEP_MS_RST;
         low_ff <= RATE_LOW_RST;
         high_ff <= RATE_HIGH_RST;
         preset_cfg_ff <= RING_PRESET_RST;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_FINGER_THRESHOLD: thr_ff <= csr.data[IR_W-1:0];
            CSR_STABILIZE_MS:     stab_ff <= csr.data[MS_W-1:0];
            CSR_MONITOR_MS:       mon_ff <= csr.data[MS_W-1:0];
            CSR_SLEEP_MS:         sleep_ff <= csr.data[MS_W-1:0];
            CSR_RATE_LOW:         low_ff <= csr.data[RATE_W-1:0];
            CSR_RATE_HIGH:        high_ff <= csr.data[RATE_W-1:0];
            CSR_RING_PRESET:      preset_cfg_ff <= csr.data[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // ring memory, registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_READ) begin
         ring_rd_ff <= ring_mem[ptr_ff];
      end
      if (state_ff == S_UPDATE) begin
         ring_mem[ptr_ff] <= inst_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= MODE_WAIT;
         now_ff <= '0;
         last_ff <= '0;
         phase_ff <= '0;
         finger_ff <= 1'b0;
         preset_ff <= RING_PRESET_RST;
         ring_valid_ff <= '0;
         ptr_ff <= '0;
         sum_ff <= SUM_W'(RING_DEPTH * RING_PRESET_RST);
         cnt_ff <= CNT_W'(RING_DEPTH);
         avg_ff <= RING_PRESET_RST;
         div_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  req_type_ff <= req.req_type;
                  ir_ff <= req.ir_level;
                  beat_ff <= req.beat_seen;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               acc_ff <= 1'b0;
               inst_ff <= '0;
               avalid_ff <= 1'b0;
               if (req_type_ff == REQ_TICK) begin
                  state_ff <= S_DONE;
                  if (mode_ff == MODE_SLEEP && phase_in >= sleep_ff) begin
                     // end of sleep restores the reset state, with the configured ring preset
                     mode_ff <= MODE_WAIT;
                     now_ff <= '0;
                     last_ff <= '0;
                     phase_ff <= '0;
                     finger_ff <= 1'b0;
                     preset_ff <= preset_cfg_ff;
                     ring_valid_ff <= '0;
                     ptr_ff <= '0;
                     sum_ff <= SUM_W'(RING_DEPTH * preset_cfg_ff);
                     cnt_ff <= (preset_cfg_ff != '0) ? CNT_W'(RING_DEPTH) : '0;
                     avg_ff <= preset_cfg_ff;
                  end else begin
                     now_ff <= now_ff + TIME_W'(1);
                     if (mode_ff == MODE_STAB && phase_in >= stab_ff) begin
                        mode_ff <= MODE_MON;
                        phase_ff <= '0;
                     end else if (mode_ff == MODE_MON && phase_in >= mon_ff) begin
                        mode_ff <= MODE_SLEEP;
                        phase_ff <= '0;
                     end else if (mode_ff != MODE_WAIT) begin
                        phase_ff <= phase_in;
                     end
                  end
               end else if (mode_ff != MODE_SLEEP) begin
                  finger_ff <= finger_in;
                  if (finger_in && beat_ff) begin
                     delta_ff <= now_ff - last_ff;
                     last_ff <= now_ff;
                     mon_beat_ff <= (mode_ff == MODE_MON);
                     state_ff <= S_CHECK;
                  end else begin
                     state_ff <= S_DONE;
                  end
                  if (mode_ff == MODE_WAIT) begin
                     if (finger_in) begin
                        mode_ff <= MODE_STAB;
                        phase_ff <= '0;
                     end
                  end else if (!finger_in) begin
                     mode_ff <= MODE_WAIT;
                     phase_ff <= '0;
                  end
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_CHECK: begin
               if (rate_ok) begin
                  div_rem_ff <= '0;
                  div_quo_ff <= RATE_NUM;
                  div_den_ff <= (delta_ff[TIME_W-1:DIV_W] != '0)
                              ? ((DIV_W+1)'(1) << DIV_W)
                              : {1'b0, delta_ff[DIV_W-1:0]};
                  div_cnt_ff <= DIV_CNT_W'(DIV_W);
                  state_ff <= S_DIV_RATE;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DIV_RATE: begin
               div_rem_ff <= rem_in;
               div_quo_ff <= quo_in;
               div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(1)) begin
                  inst_ff <= quo_in[RATE_W-1:0];
                  acc_ff <= 1'b1;
                  avalid_ff <= mon_beat_ff;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               ring_valid_ff[ptr_ff] <= 1'b1;
               ptr_ff <= ptr_in;
               sum_ff <= sum_in;
               cnt_ff <= cnt_in;
               if (cnt_in != '0) begin
                  div_rem_ff <= '0;
                  div_quo_ff <= DIV_W'(sum_in);
                  div_den_ff <= (DIV_W+1)'(cnt_in);
                  div_cnt_ff <= DIV_CNT_W'(DIV_W);
                  state_ff <= S_DIV_AVG;
               end else begin
                  avg_ff <= '0;
                  state_ff <= S_DONE;
               end
            end
            S_DIV_AVG: begin
               div_rem_ff <= rem_in;
               div_quo_ff <= quo_in;
               div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(1)) begin
                  avg_ff <= quo_in[RATE_W-1:0];
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mode_ff <= mode_ff;
                  rsp_finger_ff <= finger_ff;
                  rsp_acc_ff <= acc_ff;
                  rsp_inst_ff <= inst_ff;
                  rsp_avalid_ff <= avalid_ff;
                  rsp_avg_ff <= avg_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RING_DEPTH))
      else $error("nonzero entry count exceeds ring depth");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(RING_DEPTH - 1))
      else $error("ring pointer out of range");

   a_avalid_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_avalid_ff |-> rsp_acc_ff)
      else $error("average marked valid without an accepted beat");

   a_inst_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_acc_ff |-> rsp_inst_ff == '0)
      else $error("instant rate nonzero on a rejected request");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> div_cnt_ff == '0)
      else $error("divider busy while idle");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import hrsm_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic            req_type;
      logic [IR_W-1:0] ir_level;
      logic            beat_seen;
   } sensor_req_type;

   typedef struct {
      logic [1:0]        mode;
      logic              finger_present;
      logic              beat_accepted;
      logic [RATE_W-1:0] instant_rate;
      logic              avg_valid;
      logic [RATE_W-1:0] avg_rate;
   } session_rsp_type;

   logic clock;
   logic reset;

   hrsm_req_if req_bus ();
   hrsm_rsp_if rsp_bus ();
   hrsm_csr_if csr_bus ();

   heart_rate_session_monitor_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   sensor_req_type  sensor_queue[$];
   session_rsp_type predicted_reports[$];
   int              mismatch_count = 0;
   int              queued_total = 0;
   int              accepted_total;
   int              hold_left;
   int              next_hold_at;

   // session model state and register copies
   logic [IR_W-1:0]   cfg_thresh;
   logic [MS_W-1:0]   cfg_stab;
   logic [MS_W-1:0]   cfg_mon;
   logic [MS_W-1:0]   cfg_sleep;
   logic [RATE_W-1:0] cfg_low;
   logic [RATE_W-1:0] cfg_high;
   logic [RATE_W-1:0] cfg_preset;

   mode_type          mode_q;
   logic [TIME_W-1:0] now_q;
   logic [TIME_W-1:0] last_beat_q;
   logic [MS_W-1:0]   phase_q;
   logic              finger_q;
   logic [RATE_W-1:0] ring_q [RING_DEPTH];
   int                ring_ptr;

   // beat spacing for the current register setting
   int gap_lo;
   int gap_hi;
   int low_gap;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic void clear_session();
      mode_q = MODE_WAIT;
      now_q = '0;
      last_beat_q = '0;
      phase_q = '0;
      finger_q = 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) ring_q[i] = cfg_preset;
      ring_ptr = 0;
   endfunction

   function automatic logic [RATE_W-1:0] ring_average();
      int unsigned sum;
      int unsigned cnt;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         if (ring_q[i] != 0) begin
            sum += ring_q[i];
            cnt++;
         end
      end
      return (cnt == 0) ? '0 : RATE_W'(sum / cnt);
   endfunction

   task automatic advance_session(input sensor_req_type rq);
      session_rsp_type r;
      logic [63:0]     span;
      r.beat_accepted = 1'b0;
      r.instant_rate = '0;
      r.avg_valid = 1'b0;
      if (rq.req_type == REQ_TICK) begin
         now_q = now_q + 1'b1;
         if (mode_q != MODE_WAIT) begin
            phase_q = phase_q + 1'b1;
            if (mode_q == MODE_STAB && phase_q >= cfg_stab) begin
               mode_q = MODE_MON;
               phase_q = '0;
            end else if (mode_q == MODE_MON && phase_q >= cfg_mon) begin
               mode_q = MODE_SLEEP;
               phase_q = '0;
            end else if (mode_q == MODE_SLEEP && phase_q >= cfg_sleep) begin
               clear_session();
            end
         end
      end else if (mode_q != MODE_SLEEP) begin
         finger_q = (rq.ir_level > cfg_thresh);
         if (finger_q && rq.beat_seen) begin
            span = {32'd0, now_q - last_beat_q};
            last_beat_q = now_q;
            if (({56'd0, cfg_low} * span < 64'(RATE_NUM)) &&
                ({56'd0, cfg_high} * span > 64'(RATE_NUM))) begin
               r.instant_rate = RATE_W'(64'(RATE_NUM) / span);
               r.beat_accepted = 1'b1;
               ring_q[ring_ptr] = r.instant_rate;
               ring_ptr = (ring_ptr + 1) % RING_DEPTH;
               if (mode_q == MODE_MON) r.avg_valid = 1'b1;
            end
         end
         if (mode_q == MODE_WAIT) begin
            if (finger_q) begin
               mode_q = MODE_STAB;
               phase_q = '0;
            end
         end else if (!finger_q) begin
            mode_q = MODE_WAIT;
            phase_q = '0;
         end
      end
      r.mode = mode_q;
      r.finger_present = finger_q;
      r.avg_rate = ring_average();
      predicted_reports.push_back(r);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("error at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   function automatic bit no_idle();
      return accepted_total >= 300 && accepted_total < 560;
   endfunction

   // request driver
   always @(posedge clock) begin : drive_requests
      sensor_req_type nxt;
      logic           busy;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.req_type <= REQ_TICK;
         req_bus.ir_level <= '0;
         req_bus.beat_seen <= 1'b0;
         accepted_total <= 0;
      end else begin
         busy = req_bus.valid && !req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            nxt.req_type = req_bus.req_type;
            nxt.ir_level = req_bus.ir_level;
            nxt.beat_seen = req_bus.beat_seen;
            advance_session(nxt);
            accepted_total <= accepted_total + 1;
         end
         if (!busy) begin
            if (sensor_queue.size() != 0 && (no_idle() || $urandom_range(99) >= 10)) begin
               nxt = sensor_queue.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.req_type <= nxt.req_type;
               req_bus.ir_level <= nxt.ir_level;
               req_bus.beat_seen <= nxt.beat_seen;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long response hold-off so the block backs up
   always @(posedge clock) begin : response_hold
      if (reset) begin
         hold_left <= 0;
         next_hold_at <= 150;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (accepted_total >= next_hold_at) begin
         hold_left <= HOLD_CYCLES;
         next_hold_at <= next_hold_at + 500;
      end
   end

   // response monitor
   always @(posedge clock) begin : check_responses
      session_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_reports.size() == 0) begin
               report_mismatch($sformatf("response with nothing expected, mode %0d avg %0d",
                                         rsp_bus.mode, rsp_bus.avg_rate));
            end else begin
               want = predicted_reports.pop_front();
               check_field("mode", rsp_bus.mode, want.mode);
               check_field("finger_present", rsp_bus.finger_present, want.finger_present);
               check_field("beat_accepted", rsp_bus.beat_accepted, want.beat_accepted);
               check_field("instant_rate", rsp_bus.instant_rate, want.instant_rate);
               check_field("avg_valid", rsp_bus.avg_valid, want.avg_valid);
               check_field("avg_rate", rsp_bus.avg_rate, want.avg_rate);
            end
         end
         rsp_bus.ready <= (hold_left == 0) && (no_idle() || $urandom_range(99) >= 10);
      end
   end

   task automatic push_item(input logic kind, input logic [IR_W-1:0] ir, input logic beat);
      sensor_req_type it;
      it.req_type = kind;
      it.ir_level = ir;
      it.beat_seen = beat;
      sensor_queue.push_back(it);
      queued_total++;
   endtask

   function automatic logic [IR_W-1:0] finger_ir();
      int unsigned room;
      room = (2 ** IR_W - 1) - cfg_thresh;
      if (room == 0) return IR_W'($urandom);
      if ($urandom_range(1)) return cfg_thresh + IR_W'($urandom_range(room < 3 ? room : 3, 1));
      return cfg_thresh + IR_W'($urandom_range(room, 1));
   endfunction

   function automatic logic [IR_W-1:0] no_finger_ir();
      if ($urandom_range(1)) return cfg_thresh;
      return IR_W'($urandom_range(cfg_thresh));
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_FINGER_THRESHOLD: cfg_thresh = val[IR_W-1:0];
         CSR_STABILIZE_MS:     cfg_stab = val[MS_W-1:0];
         CSR_MONITOR_MS:       cfg_mon = val[MS_W-1:0];
         CSR_SLEEP_MS:         cfg_sleep = val[MS_W-1:0];
         CSR_RATE_LOW:         cfg_low = val[RATE_W-1:0];
         CSR_RATE_HIGH:        cfg_high = val[RATE_W-1:0];
         CSR_RING_PRESET:      cfg_preset = val[RATE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure_session(input logic [IR_W-1:0] thresh, input logic [MS_W-1:0] stab,
                                    input logic [MS_W-1:0] mon, input logic [MS_W-1:0] slp,
                                    input logic [RATE_W-1:0] rate_lo,
                                    input logic [RATE_W-1:0] rate_hi,
                                    input logic [RATE_W-1:0] preset);
      int min_delta;
      write_reg(CSR_FINGER_THRESHOLD, CSR_DATA_W'(thresh));
      write_reg(CSR_STABILIZE_MS, CSR_DATA_W'(stab));
      write_reg(CSR_MONITOR_MS, CSR_DATA_W'(mon));
      write_reg(CSR_SLEEP_MS, CSR_DATA_W'(slp));
      write_reg(CSR_RATE_LOW, CSR_DATA_W'(rate_lo));
      write_reg(CSR_RATE_HIGH, CSR_DATA_W'(rate_hi));
      write_reg(CSR_RING_PRESET, CSR_DATA_W'(preset));
      min_delta = 60000 / ((rate_hi == 0) ? 1 : rate_hi);
      gap_lo = (min_delta > 3) ? min_delta - 3 : 1;
      gap_hi = min_delta + 20;
      low_gap = (rate_lo == 0) ? 0 : 60000 / rate_lo;
   endtask

   task automatic queue_random_steps(input int budget);
      int sel;
      int gap;
      int pick;
      int start;
      start = queued_total;
      while (queued_total - start < budget) begin
         sel = $urandom_range(99);
         if (sel < 30) begin
            // beat after a run of ticks, mostly near the upper rate limit
            pick = $urandom_range(99);
            if (pick < 80) gap = $urandom_range(gap_hi, gap_lo);
            else if (pick < 90) gap = $urandom_range(3);
            else if (low_gap != 0 && low_gap < 400) gap = $urandom_range(low_gap + 3, low_gap - 3);
            else gap = $urandom_range(gap_hi, gap_lo);
            if (gap > budget - (queued_total - start)) gap = $urandom_range(3);
            repeat (gap) push_item(REQ_TICK, IR_W'($urandom), 1'($urandom));
            push_item(REQ_SAMPLE, finger_ir(), 1'b1);
         end else if (sel < 50) begin
            push_item(REQ_SAMPLE, finger_ir(), 1'b0);
         end else if (sel < 54) begin
            push_item(REQ_SAMPLE, no_finger_ir(), 1'($urandom));
         end else if (sel < 74) begin
            repeat ($urandom_range(30, 1)) push_item(REQ_TICK, IR_W'($urandom), 1'($urandom));
         end else if (sel < 90) begin
            push_item(REQ_SAMPLE, IR_W'($urandom), 1'($urandom));
         end else begin
            push_item(REQ_SAMPLE, finger_ir(), 1'b1);
         end
      end
   endtask

   task automatic wait_drain();
      while (sensor_queue.size() != 0 || predicted_reports.size() != 0 || req_bus.valid)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      reset = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_FINGER_THRESHOLD;
      csr_bus.data = '0;
      cfg_thresh = FINGER_THRESHOLD_RST;
      cfg_stab = STABILIZE_MS_RST;
      cfg_mon = MONITOR_MS_RST;
      cfg_sleep = SLEEP_MS_RST;
      cfg_low = RATE_LOW_RST;
      cfg_high = RATE_HIGH_RST;
      cfg_preset = RING_PRESET_RST;
      clear_session();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: threshold edges, beat without finger, zero interval
      push_item(REQ_TICK, '0, 1'b0);
      push_item(REQ_SAMPLE, '0, 1'b1);
      push_item(REQ_SAMPLE, IR_W'(FINGER_THRESHOLD_RST), 1'b1);
      push_item(REQ_SAMPLE, IR_W'(FINGER_THRESHOLD_RST) + 1'b1, 1'b0);
      push_item(REQ_SAMPLE, {IR_W{1'b1}}, 1'b1);
      push_item(REQ_SAMPLE, {IR_W{1'b1}}, 1'b1);
      repeat (3) push_item(REQ_TICK, {IR_W{1'b1}}, 1'b1);
      push_item(REQ_SAMPLE, '0, 1'b0);
      push_item(REQ_SAMPLE, 18'h2AAAA, 1'b1);
      push_item(REQ_SAMPLE, 18'h15555, 1'b0);
      wait_drain();

      // zero stabilize duration, zero threshold, zero preset, sample while asleep
      configure_session('0, '0, 20'd1, 20'd2, 8'd0, 8'd255, 8'd0);
      push_item(REQ_TICK, '0, 1'b0);
      push_item(REQ_TICK, '0, 1'b0);
      push_item(REQ_SAMPLE, {IR_W{1'b1}}, 1'b1);
      push_item(REQ_TICK, '0, 1'b0);
      push_item(REQ_TICK, '0, 1'b0);
      push_item(REQ_SAMPLE, '0, 1'b1);
      push_item(REQ_SAMPLE, 18'd1, 1'b1);
      push_item(REQ_TICK, '0, 1'b0);
      push_item(REQ_SAMPLE, {IR_W{1'b1}}, 1'b0);
      wait_drain();

      configure_session(18'd50000, 20'd30, 20'd600, 20'd40, 8'd1, 8'd255, 8'd255);
      queue_random_steps(280);
      wait_drain();

      configure_session(IR_W'($urandom_range(120000, 20000)), MS_W'($urandom_range(60, 20)),
                        MS_W'($urandom_range(600, 300)), MS_W'($urandom_range(40, 10)),
                        8'd40, 8'd250, 8'd70);
      queue_random_steps(280);
      wait_drain();

      // crossed limits
      configure_session(18'd50000, 20'd20, 20'd200, 20'd20, 8'd200, 8'd100, 8'd70);
      queue_random_steps(60);
      wait_drain();

      configure_session({IR_W{1'b1}}, {MS_W{1'b1}}, {MS_W{1'b1}}, {MS_W{1'b1}},
                        8'd255, 8'd255, 8'd1);
      queue_random_steps(30);
      wait_drain();

      configure_session('0, 20'd1, 20'd200, 20'd1, 8'd0, 8'd250, 8'd0);
      queue_random_steps(280);
      wait_drain();

      configure_session(IR_W'($urandom_range(200000)), MS_W'($urandom_range(50, 10)),
                        MS_W'($urandom_range(500, 200)), MS_W'($urandom_range(30, 1)),
                        RATE_W'($urandom_range(60, 1)), RATE_W'($urandom_range(255, 230)),
                        RATE_W'($urandom_range(255, 1)));
      queue_random_steps(280);
      wait_drain();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
